// ===== sv/nct_pkg.sv =====
// ----------------------------------------------------------------------------
// nct_pkg
// shared types and constants of the nearest centroid tracker
// ----------------------------------------------------------------------------
package nct_pkg;

	localparam int BOX_W       = 12;
	localparam int CX_W        = 14;
	localparam int SQ_W        = 2 * CX_W;
	localparam int D2_W        = SQ_W + 1;
	localparam int LIM_W       = BOX_W + 1;
	localparam int ID_OUT_W    = 16;
	localparam int CNT_OUT_W   = 7;

	localparam int MAX_TRACKS_DEF = 64;
	localparam int ID_BITS_DEF    = 16;

	localparam logic [BOX_W-1:0] MAX_DIST_RST = 12'd50;

	localparam logic FUNC_DET = 1'b0;
	localparam logic FUNC_EOF = 1'b1;

	typedef struct packed {
		logic             func;
		logic [BOX_W-1:0] box_x;
		logic [BOX_W-1:0] box_y;
		logic [BOX_W-1:0] box_width;
		logic [BOX_W-1:0] box_height;
	} item_t;

	typedef struct packed {
		logic [ID_OUT_W-1:0]  vehicle_id;
		logic                 is_new;
		logic                 table_full;
		logic [CNT_OUT_W-1:0] tracked_count;
	} result_t;

	typedef struct packed {
		logic init;
		logic vld;
	} dist_ctl_t;

endpackage

// ===== sv/nct_track_mem.sv =====
// ----------------------------------------------------------------------------
// nct_track_mem
// track table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module nct_track_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 44
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/nct_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nct_dist_unit
// squared centroid distance and running nearest-track selection
// ----------------------------------------------------------------------------
module nct_dist_unit #(
	parameter int ID_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  nct_pkg::dist_ctl_t                        ctl,
	input  logic [nct_pkg::BOX_W-1:0]                 max_distance,
	input  logic [nct_pkg::CX_W-1:0]                  cx,
	input  logic [nct_pkg::CX_W-1:0]                  cy,
	input  logic [ID_BITS+2*nct_pkg::CX_W-1:0]        entry,
	output logic                                      busy,
	output logic                                      found,
	output logic [ID_BITS-1:0]                        best_id
);
	import nct_pkg::*;

	localparam int ENT_W = ID_BITS + 2 * CX_W;

	logic [ID_BITS-1:0] e_id;
	logic [CX_W-1:0]    e_cx;
	logic [CX_W-1:0]    e_cy;
	logic [CX_W-1:0]    dx;
	logic [CX_W-1:0]    dy;
	logic [LIM_W-1:0]   lim;
	logic [SQ_W-1:0]    dx2_s2;
	logic [SQ_W-1:0]    dy2_s2;
	logic [ID_BITS-1:0] id_s2;
	logic               vld_s2;
	logic [D2_W-1:0]    d2;
	logic [D2_W-1:0]    best_q;
	logic [ID_BITS-1:0] best_id_q;
	logic               found_q;
	logic               better;

	assign e_id = entry[ENT_W-1 -: ID_BITS];
	assign e_cx = entry[2*CX_W-1 -: CX_W];
	assign e_cy = entry[CX_W-1:0];
	assign dx   = (cx >= e_cx) ? cx - e_cx : e_cx - cx;
	assign dy   = (cy >= e_cy) ? cy - e_cy : e_cy - cy;
	assign lim  = {max_distance, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		dx2_s2 <= SQ_W'(dx) * SQ_W'(dx);
		dy2_s2 <= SQ_W'(dy) * SQ_W'(dy);
		id_s2  <= e_id;
	end

	assign d2     = D2_W'(dx2_s2) + D2_W'(dy2_s2);
	assign better = (d2 < best_q) || (found_q && d2 == best_q && id_s2 < best_id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (vld_s2 && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			best_q <= D2_W'(lim) * D2_W'(lim);
		end else if (vld_s2 && better) begin
			best_q    <= d2;
			best_id_q <= id_s2;
		end
	end

	assign busy    = vld_s2;
	assign found   = found_q;
	assign best_id = best_id_q;

endmodule

// ===== sv/nearest_centroid_tracker_core.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_tracker_core
// nearest-neighbour centroid tracker with double-buffered track tables
// ----------------------------------------------------------------------------
// item channel (item_valid / item_stall / item): a detection box, or an end of
// frame beat that makes the table built this frame current.
// result channel (result_valid / result_stall / result): one beat per item,
// held in an output register while result_stall is high; the next item is
// taken meanwhile and waits in its final step until the register frees.
// cfg channel (cfg_valid / cfg_ready / cfg_data): max_distance, always ready.
// both tables live in one memory, current bank and next bank, read one entry
// a cycle. a detection makes one pass over the current bank for the nearest
// track, one pass over the next bank for a repeated id, then the write-back.
// an end of frame beat skips both passes and goes straight to the final step.
// reset empties both tables through their counts, zeroes the id counter and
// sets max_distance to 50; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_centroid_tracker_core #(
	parameter int MAX_TRACKS = nct_pkg::MAX_TRACKS_DEF,
	parameter int ID_BITS    = nct_pkg::ID_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  nct_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output nct_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [nct_pkg::BOX_W-1:0] cfg_data
);
	import nct_pkg::*;

	localparam int IW    = $clog2(MAX_TRACKS);
	localparam int CW    = $clog2(MAX_TRACKS + 1);
	localparam int AW    = IW + 1;
	localparam int ENT_W = ID_BITS + 2 * CX_W;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_SCAN_CUR = 2'd1;
	localparam logic [1:0] ST_SCAN_NXT = 2'd2;
	localparam logic [1:0] ST_FIN      = 2'd3;

	logic [1:0]         state_q;
	logic [BOX_W-1:0]   max_dist_q;
	logic               bank_q;
	logic [CW-1:0]      cur_count_q;
	logic [CW-1:0]      next_fill_q;
	logic [ID_BITS-1:0] id_cnt_q;
	logic [CW-1:0]      rd_idx_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic               eof_q;
	logic [CX_W-1:0]    cx_q;
	logic [CX_W-1:0]    cy_q;
	logic [ID_BITS-1:0] vid_q;
	logic               fresh_q;
	logic               placed_q;
	logic [IW-1:0]      place_idx_q;
	logic               result_valid_q;
	result_t            result_q;

	logic               accept;
	logic               out_free;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENT_W-1:0]   rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENT_W-1:0]   wr_data;
	logic               has_room;
	logic               cur_done;
	logic               nxt_done;
	logic               id_hit;
	dist_ctl_t          dctl;
	logic               dist_busy;
	logic               dist_found;
	logic [ID_BITS-1:0] dist_best_id;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// read sequencing over the current bank, then the next bank
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {bank_q, rd_idx_q[IW-1:0]};
		unique case (state_q)
			ST_SCAN_CUR: begin
				rd_en = (rd_idx_q < cur_count_q);
			end
			ST_SCAN_NXT: begin
				rd_en   = (rd_idx_q < next_fill_q);
				rd_addr = {~bank_q, rd_idx_q[IW-1:0]};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign cur_done = (rd_idx_q == cur_count_q) && !rd_vld_s1 && !dist_busy;
	assign nxt_done = (rd_idx_q == next_fill_q) && !rd_vld_s1;
	assign id_hit   = rd_vld_s1 && (state_q == ST_SCAN_NXT) && !placed_q &&
	                  (rd_data[ENT_W-1 -: ID_BITS] == vid_q);
	assign has_room = (next_fill_q < CW'(MAX_TRACKS));

	assign dctl.init = accept && (item.func == FUNC_DET);
	assign dctl.vld  = rd_vld_s1 && (state_q == ST_SCAN_CUR);

	// write-back of the detection into the next bank
	assign wr_en   = (state_q == ST_FIN) && out_free && !eof_q && (placed_q || has_room);
	assign wr_addr = {~bank_q, placed_q ? place_idx_q : next_fill_q[IW-1:0]};
	assign wr_data = {vid_q, cx_q, cy_q};

	nct_track_mem #(
		.DEPTH (2 * (1 << IW)),
		.WIDTH (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nct_dist_unit #(
		.ID_BITS (ID_BITS)
	) u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (dctl),
		.max_distance (max_dist_q),
		.cx           (cx_q),
		.cy           (cy_q),
		.entry        (rd_data),
		.busy         (dist_busy),
		.found        (dist_found),
		.best_id      (dist_best_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= MAX_DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_dist_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bank_q         <= 1'b0;
			cur_count_q    <= '0;
			next_fill_q    <= '0;
			id_cnt_q       <= '0;
			rd_idx_q       <= '0;
			rd_vld_s1      <= 1'b0;
			eof_q          <= 1'b0;
			fresh_q        <= 1'b0;
			placed_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == ST_FIN && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (id_hit) begin
				placed_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eof_q    <= (item.func == FUNC_EOF);
						placed_q <= 1'b0;
						rd_idx_q <= '0;
						state_q  <= (item.func == FUNC_EOF) ? ST_FIN : ST_SCAN_CUR;
					end
				end
				ST_SCAN_CUR: begin
					if (cur_done) begin
						fresh_q  <= !dist_found;
						rd_idx_q <= '0;
						state_q  <= ST_SCAN_NXT;
						if (!dist_found) begin
							id_cnt_q <= id_cnt_q + 1'b1;
						end
					end
				end
				ST_SCAN_NXT: begin
					if (nxt_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (eof_q) begin
							bank_q      <= ~bank_q;
							cur_count_q <= next_fill_q;
							next_fill_q <= '0;
						end else if (!placed_q && has_room) begin
							next_fill_q <= next_fill_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[IW-1:0];
		if (accept) begin
			cx_q <= {1'b0, item.box_x, 1'b0} + CX_W'(item.box_width);
			cy_q <= {1'b0, item.box_y, 1'b0} + CX_W'(item.box_height);
		end
		if (state_q == ST_SCAN_CUR && cur_done) begin
			vid_q <= dist_found ? dist_best_id : id_cnt_q;
		end
		if (id_hit) begin
			place_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_FIN && out_free) begin
			if (eof_q) begin
				result_q.vehicle_id    <= '0;
				result_q.is_new        <= 1'b0;
				result_q.table_full    <= 1'b0;
				result_q.tracked_count <= CNT_OUT_W'(next_fill_q);
			end else begin
				result_q.vehicle_id    <= ID_OUT_W'(vid_q);
				result_q.is_new        <= fresh_q;
				result_q.table_full    <= !placed_q && !has_room;
				result_q.tracked_count <= '0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_fill_q <= CW'(MAX_TRACKS)) && (cur_count_q <= CW'(MAX_TRACKS)))
		else $error("track count beyond table depth");

	a_wr_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_FIN) && !rd_en)
		else $error("memory write outside write-back step");

	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == ST_SCAN_CUR || state_q == ST_SCAN_NXT))
		else $error("memory read outside a scan");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result loaded outside write-back step");

	a_fresh_id: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CUR && cur_done && !dist_found)
		|=> id_cnt_q == ID_BITS'($past(id_cnt_q) + 1'b1))
		else $error("id counter did not advance on fresh id");

endmodule
